>>> rtl/slist_pkg.sv
// Shared types and constants for the sorted list block.
`timescale 1ns / 1ps

package slist_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FIELD_W         = 5;
    localparam int STATUS_W        = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

>>> rtl/slist_cmd_if.sv
// Command channel: valid/ready handshake with command and value payload.
`timescale 1ns / 1ps

interface slist_cmd_if #(
    parameter int VALUE_WIDTH = slist_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

>>> rtl/slist_res_if.sv
// Result channel: valid/ready handshake with status, position and count payload.
`timescale 1ns / 1ps

interface slist_res_if;
    logic                             valid;
    logic                             ready;
    logic [slist_pkg::STATUS_W-1:0]   status;
    logic [slist_pkg::FIELD_W-1:0]    position;
    logic [slist_pkg::FIELD_W-1:0]    count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

>>> rtl/slist_cell.sv
// One storage cell of the sorted chain: holds a value, compares it, shifts with neighbors.
`timescale 1ns / 1ps

module slist_cell #(
    parameter int VALUE_WIDTH = slist_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  slist_pkg::t_cell_ctrl   i_ctrl,
    input  logic [VALUE_WIDTH-1:0]  i_key,
    input  logic [VALUE_WIDTH-1:0]  i_left_value,
    input  logic                    i_left_valid,
    input  logic                    i_left_less,
    input  logic [VALUE_WIDTH-1:0]  i_right_value,
    input  logic                    i_right_valid,
    output logic [VALUE_WIDTH-1:0]  o_value,
    output logic                    o_valid,
    output logic                    o_less,
    output logic                    o_eq
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   r_valid;
    logic                   n_valid;

    assign o_less  = r_valid && ($signed(r_value) < $signed(i_key));
    assign o_eq    = r_valid && (r_value == i_key);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins && !o_less) begin
            // first cell not below the key takes the key, the rest shift right
            if (i_left_less) begin
                n_value = i_key;
                n_valid = 1'b1;
            end else begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
        end else if (i_ctrl.rem && !o_less) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

>>> rtl/slist_enc.sv
// Boundary encoder: turns the prefix of below-key cells into a position and a match flag.
`timescale 1ns / 1ps

module slist_enc #(
    parameter int CAPACITY = slist_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic [CAPACITY-1:0] i_less,
    input  logic [CAPACITY-1:0] i_eq,
    output logic [CNT_W-1:0]    o_pos,
    output logic                o_hit
);

    logic [CAPACITY:0] w_cur;
    logic [CAPACITY:0] w_prev;
    logic [CAPACITY:0] w_eq;
    logic [CAPACITY:0] w_edge;

    assign w_cur  = {1'b0, i_less};
    assign w_prev = {i_less, 1'b1};
    assign w_eq   = {1'b0, i_eq};
    // exactly one edge: the first slot whose value is not below the key
    assign w_edge = w_prev & ~w_cur;

    always_comb begin
        o_pos = '0;
        o_hit = 1'b0;
        for (int i = 0; i <= CAPACITY; i++) begin
            if (w_edge[i]) begin
                o_pos = o_pos | CNT_W'(i);
            end
            o_hit = o_hit | (w_edge[i] & w_eq[i]);
        end
    end

endmodule

>>> rtl/sorted_list_insert_remove.sv
// Sorted list top level: chain of cells, boundary encoder and result register.
//
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// Command channel i_cmd: command 0 inserts value ahead of the first stored
// value that is not smaller; command 1 removes the first stored value equal
// to value. Result channel o_res returns one word per command: status
// (0 done, 1 no match, 2 table full), position acted on (count when nothing
// was done) and the count after the command, position and count modulo 32.
// Every cell compares its value with the command value in the accept cycle;
// the below-key cells form a prefix, so one encoder finds the position and
// all cells shift in the same edge.
// Latency: the result is valid in the cycle after the command word is taken.
// Throughput: one command per cycle while o_res.ready is high; the single
// result register sets that figure.
// Reset empties the table and drops any pending result. When the receiver
// stalls, the result holds and i_cmd.ready falls until it is taken.
`timescale 1ns / 1ps

module sorted_list_insert_remove #(
    parameter int CAPACITY    = slist_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = slist_pkg::VALUE_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    slist_cmd_if.sink        i_cmd,
    slist_res_if.source      o_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                        w_accept;
    logic                        w_is_insert;
    logic                        w_full;
    logic                        w_hit;
    logic [CNT_W-1:0]            w_pos;
    slist_pkg::t_cell_ctrl       w_ctrl;
    logic [CAPACITY-1:0]         w_less;
    logic [CAPACITY-1:0]         w_eq;
    logic [CAPACITY-1:0]         w_valid;
    logic [VALUE_WIDTH-1:0]      w_value [CAPACITY];

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    slist_pkg::t_status          r_status;
    slist_pkg::t_status          n_status;
    logic [CNT_W-1:0]            r_position;
    logic [CNT_W-1:0]            n_position;
    logic [31:0]                 w_pos_wide;
    logic [31:0]                 w_cnt_wide;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_is_insert = (slist_pkg::t_cmd'(i_cmd.command) == slist_pkg::CMD_INSERT);
    assign w_full      = w_valid[CAPACITY-1];

    assign w_ctrl.ins = w_accept && w_is_insert && !w_full;
    assign w_ctrl.rem = w_accept && !w_is_insert && w_hit;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_lv;
        logic                   w_lval;
        logic                   w_lless;
        logic [VALUE_WIDTH-1:0] w_rv;
        logic                   w_rval;

        if (g == 0) begin : g_first
            assign w_lv    = '0;
            assign w_lval  = 1'b0;
            assign w_lless = 1'b1;
        end else begin : g_mid
            assign w_lv    = w_value[g-1];
            assign w_lval  = w_valid[g-1];
            assign w_lless = w_less[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rv   = '0;
            assign w_rval = 1'b0;
        end else begin : g_inner
            assign w_rv   = w_value[g+1];
            assign w_rval = w_valid[g+1];
        end

        slist_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_key         (i_cmd.value),
            .i_left_value  (w_lv),
            .i_left_valid  (w_lval),
            .i_left_less   (w_lless),
            .i_right_value (w_rv),
            .i_right_valid (w_rval),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_less        (w_less[g]),
            .o_eq          (w_eq[g])
        );
    end

    slist_enc #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_enc (
        .i_less (w_less),
        .i_eq   (w_eq),
        .o_pos  (w_pos),
        .o_hit  (w_hit)
    );

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_position  = r_position;
        if (w_accept) begin
            n_out_valid = 1'b1;
            if (w_ctrl.ins) begin
                n_count    = r_count + CNT_W'(1);
                n_status   = slist_pkg::ST_DONE;
                n_position = w_pos;
            end else if (w_ctrl.rem) begin
                n_count    = r_count - CNT_W'(1);
                n_status   = slist_pkg::ST_DONE;
                n_position = w_pos;
            end else begin
                n_status   = w_is_insert ? slist_pkg::ST_FULL : slist_pkg::ST_NO_MATCH;
                n_position = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_position <= n_position;
    end

    // report position and count modulo 32
    assign w_pos_wide = 32'(r_position);
    assign w_cnt_wide = 32'(r_count);

    assign o_res.valid    = r_out_valid;
    assign o_res.status   = r_status;
    assign o_res.position = w_pos_wide[slist_pkg::FIELD_W-1:0];
    assign o_res.count    = w_cnt_wide[slist_pkg::FIELD_W-1:0];

endmodule

>>> rtl/slist_chk.sv
// Port-level checker for the sorted list block, bound to the top level.
`timescale 1ns / 1ps

module slist_chk #(
    parameter int CAPACITY = slist_pkg::CAPACITY_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic [slist_pkg::STATUS_W-1:0]   i_status,
    input logic [slist_pkg::FIELD_W-1:0]    i_position,
    input logic [slist_pkg::FIELD_W-1:0]    i_count
);

    localparam logic [slist_pkg::FIELD_W-1:0] CAP_FIELD =
        slist_pkg::FIELD_W'(CAPACITY % 32);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result word valid after reset");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status != slist_pkg::ST_DONE) |-> (i_position == i_count))
        else $error("position differs from count on a command that did nothing");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status == slist_pkg::ST_FULL) |-> (i_count == CAP_FIELD))
        else $error("full status with a count below capacity");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_status == slist_pkg::ST_DONE ||
                         i_status == slist_pkg::ST_NO_MATCH ||
                         i_status == slist_pkg::ST_FULL))
        else $error("undefined status code");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_status) && $stable(i_position) && $stable(i_count)))
        else $error("stalled result word changed");

endmodule

bind sorted_list_insert_remove slist_chk #(
    .CAPACITY (CAPACITY)
) u_slist_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_position  (o_res.position),
    .i_count     (o_res.count)
);
